@@ src/stks_pkg.sv @@
// ----------------------------------------------------------------------------
// stks_pkg
// Shared constants and types for the streaming top-k selector.
// ----------------------------------------------------------------------------
package stks_pkg;

  localparam int MAX_K     = 8;
  localparam int MAX_ITEMS = 1024;
  localparam int Q_DEPTH   = 4;

  localparam int SCORE_W = 32;
  localparam int IDX_W   = 10;
  localparam int SEL_W   = 4;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int KE_W    = $clog2(MAX_K + 1);
  localparam int RANK_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [SEL_W-1:0] SEL_RESET = SEL_W'(8);

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          idx;
    logic                      ins;
    logic                      last;
    logic                      err;
    logic [KE_W-1:0]           k;
  } cmd_t;

  typedef struct packed {
    logic [MAX_K-1:0][SCORE_W-1:0] scores;
    logic [MAX_K-1:0][IDX_W-1:0]   idx;
    logic [MAX_K-1:0]              valid;
    logic                          err;
    logic [KE_W-1:0]               k;
  } snap_t;

endpackage

@@ src/streaming_top_k_selector.sv @@
// ----------------------------------------------------------------------------
// streaming_top_k_selector
// Keeps the k largest scores of a vector and emits them in rank order.
// Throughput: one score per cycle; k results per vector, one per ready cycle.
// First result of a vector: last score -> queue -> snapshot -> output register.
// Input stalls only if a vector ends while the previous ranking still emits.
// Reset: asynchronous, active low; lists empty, select_count = 8.
// ----------------------------------------------------------------------------
module streaming_top_k_selector import stks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] score
  input  logic        s_axis_tlast,   // last_item
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [9:0] expert_index, [41:10] expert_score
  output logic [1:0]  m_axis_tuser,   // [0] slot_filled, [1] count_error
  output logic        m_axis_tlast    // last_result
);

  logic [SEL_W-1:0]   select_count_q;
  logic               q_full, push, q_valid, q_pop, snap_load, emit_busy;
  cmd_t               push_cmd, head_cmd;
  snap_t              snap;
  logic [IDX_W-1:0]   out_index;
  logic [SCORE_W-1:0] out_score;
  logic               out_filled, out_err;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(select_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_count_q <= SEL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      select_count_q <= pwdata[SEL_W-1:0];
    end
  end

  stks_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s_axis_tvalid),
    .item_ready_o   (s_axis_tready),
    .score_i        (s_axis_tdata),
    .last_i         (s_axis_tlast),
    .select_count_i (select_count_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  stks_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_cmd)
  );

  stks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_pop),
    .cmd_i       (head_cmd),
    .emit_busy_i (emit_busy),
    .snap_load_o (snap_load),
    .snap_o      (snap)
  );

  stks_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (snap_load),
    .snap_i       (snap),
    .busy_o       (emit_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_index_o  (out_index),
    .out_score_o  (out_score),
    .out_filled_o (out_filled),
    .out_err_o    (out_err),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_score, out_index};
  assign m_axis_tuser = {out_err, out_filled};

endmodule

@@ src/stks_front.sv @@
// ----------------------------------------------------------------------------
// stks_front
// Numbers incoming scores, tracks the item limit and builds queue commands.
// ----------------------------------------------------------------------------
module stks_front import stks_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  logic [SCORE_W-1:0] score_i,
  input  logic               last_i,
  input  logic [SEL_W-1:0]   select_count_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [CNT_W-1:0] item_count_q, item_count_d;
  logic             overflow_q, overflow_d;
  logic             ins;
  logic [CNT_W-1:0] count_next;
  logic             ovf_next;
  logic [KE_W-1:0]  k_eff;

  always_comb begin
    if (select_count_i == '0) begin
      k_eff = KE_W'(1);
    end else if (int'(select_count_i) > MAX_K) begin
      k_eff = KE_W'(MAX_K);
    end else begin
      k_eff = KE_W'(select_count_i);
    end
  end

  assign item_ready_o = !q_full_i;
  assign push_o       = item_valid_i && !q_full_i;
  assign ins          = item_count_q < CNT_W'(MAX_ITEMS);
  assign count_next   = ins ? item_count_q + CNT_W'(1) : item_count_q;
  assign ovf_next     = overflow_q || !ins;

  always_comb begin
    cmd_o.score = score_i;
    cmd_o.idx   = IDX_W'(item_count_q);
    cmd_o.ins   = ins;
    cmd_o.last  = last_i;
    cmd_o.err   = (count_next < CNT_W'(k_eff)) || ovf_next;
    cmd_o.k     = k_eff;
  end

  always_comb begin
    item_count_d = item_count_q;
    overflow_d   = overflow_q;
    if (push_o) begin
      if (last_i) begin
        item_count_d = '0;
        overflow_d   = 1'b0;
      end else begin
        item_count_d = count_next;
        overflow_d   = ovf_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= '0;
      overflow_q   <= 1'b0;
    end else begin
      item_count_q <= item_count_d;
      overflow_q   <= overflow_d;
    end
  end

endmodule

@@ src/stks_fifo.sv @@
// ----------------------------------------------------------------------------
// stks_fifo
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module stks_fifo import stks_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t             mem_q [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]  count_q;
  logic             do_pop;

  assign full_o  = count_q == QC_W'(Q_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QC_W'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - QC_W'(1);
      end
    end
  end

endmodule

@@ src/stks_back.sv @@
// ----------------------------------------------------------------------------
// stks_back
// Ranked slot list: parallel compare/shift insert, one per cycle unless held.
// ----------------------------------------------------------------------------
module stks_back import stks_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  output logic  cmd_ready_o,
  input  cmd_t  cmd_i,
  input  logic  emit_busy_i,
  output logic  snap_load_o,
  output snap_t snap_o
);

  logic [MAX_K-1:0][SCORE_W-1:0] score_q, score_d;
  logic [MAX_K-1:0][IDX_W-1:0]   idx_q, idx_d;
  logic [MAX_K-1:0]              valid_q, valid_d;
  logic [MAX_K-1:0]              hit, pre;
  logic                          take;

  assign cmd_ready_o = !(cmd_i.last && emit_busy_i);
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      hit[j] = (j < int'(cmd_i.k)) && cmd_i.ins &&
               (!valid_q[j] || ($signed(cmd_i.score) > $signed(score_q[j])));
      pre[j] = (j == 0) ? hit[j] : (hit[j] || pre[j-1]);
    end
  end

  always_comb begin
    score_d = score_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    for (int j = 0; j < MAX_K; j++) begin
      if (j < int'(cmd_i.k) && pre[j]) begin
        if (j == 0 || !pre[j-1]) begin
          score_d[j] = cmd_i.score;
          idx_d[j]   = cmd_i.idx;
          valid_d[j] = 1'b1;
        end else begin
          score_d[j] = score_q[j-1];
          idx_d[j]   = idx_q[j-1];
          valid_d[j] = valid_q[j-1];
        end
      end
    end
  end

  always_comb begin
    snap_load_o   = take && cmd_i.last;
    snap_o.scores = score_d;
    snap_o.idx    = idx_d;
    snap_o.valid  = valid_d;
    snap_o.err    = cmd_i.err;
    snap_o.k      = cmd_i.k;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      score_q <= score_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (take) begin
      valid_q <= cmd_i.last ? '0 : valid_d;
    end
  end

endmodule

@@ src/stks_emit.sv @@
// ----------------------------------------------------------------------------
// stks_emit
// Holds a finished ranking and streams its slots through an output register.
// ----------------------------------------------------------------------------
module stks_emit import stks_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  snap_t              snap_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   out_index_o,
  output logic [SCORE_W-1:0] out_score_o,
  output logic               out_filled_o,
  output logic               out_err_o,
  output logic               out_last_o
);

  snap_t               snap_q;
  logic                busy_q;
  logic [RANK_W-1:0]   rank_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [SCORE_W-1:0]  out_score_q;
  logic                out_filled_q, out_err_q, out_last_q;
  logic                advance, final_rank;

  assign advance    = busy_q && (!out_valid_q || out_ready_i);
  assign final_rank = KE_W'(rank_q) == (snap_q.k - KE_W'(1));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
    if (advance) begin
      out_filled_q <= snap_q.valid[rank_q];
      out_index_q  <= snap_q.valid[rank_q] ? snap_q.idx[rank_q] : '0;
      out_score_q  <= snap_q.valid[rank_q] ? snap_q.scores[rank_q] : '0;
      out_err_q    <= snap_q.err;
      out_last_q   <= final_rank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        rank_q <= '0;
      end else if (advance) begin
        if (final_rank) begin
          busy_q <= 1'b0;
        end else begin
          rank_q <= rank_q + RANK_W'(1);
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy_o       = busy_q;
  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_score_o  = out_score_q;
  assign out_filled_o = out_filled_q;
  assign out_err_o    = out_err_q;
  assign out_last_o   = out_last_q;

endmodule
